FILE: design/sliding_window_monotonic_queue_defines.svh
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: assertion macros
// Concurrent checks used by the queue back end, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MONOTONIC_QUEUE_DEFINES_SVH
`define SLIDING_WINDOW_MONOTONIC_QUEUE_DEFINES_SVH

// same-cycle implication
`define SWMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swmq: same-cycle check failed");

// next-cycle implication
`define SWMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swmq: next-cycle check failed");

`endif

FILE: design/swmq_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: package
// Sizes, word types, compare mode codes and the tail dominance test.
// ----------------------------------------------------------------------------
package swmq_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MODE_W      = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [MODE_W-1:0] CMP_LE = 2'd0;
    localparam logic [MODE_W-1:0] CMP_LT = 2'd1;
    localparam logic [MODE_W-1:0] CMP_GE = 2'd2;
    localparam logic [MODE_W-1:0] CMP_GT = 2'd3;

    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  item_key;
        logic signed [DATA_W-1:0] item_value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] best_value;
        logic                     queue_empty;
        logic                     overflow;
    } t_result;

    typedef struct packed {
        logic                          opcode;
        logic signed [KEY_W-1:0]       key;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [KEY_W-1:0]       key;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_entry;

    function automatic logic dominated(
        input logic [MODE_W-1:0]             mode,
        input logic signed [VALUE_WIDTH-1:0] back,
        input logic signed [VALUE_WIDTH-1:0] nv
    );
        logic res;
        unique case (mode)
            CMP_LE: res = (back <= nv);
            CMP_LT: res = (back <  nv);
            CMP_GE: res = (back >= nv);
            CMP_GT: res = (back >  nv);
        endcase
        return res;
    endfunction

endpackage

FILE: design/swmq_front.sv
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: front end
// Accepts items, wraps the value to the store width and queues the command.
// ----------------------------------------------------------------------------
module swmq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  swmq_pkg::t_item i_item,
    output logic           o_busy,
    input  logic           i_pop,
    output logic           o_cmd_valid,
    output swmq_pkg::t_cmd o_cmd
);
    import swmq_pkg::*;

    t_cmd              r_slot [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FCNT_W-1:0] r_fill, n_fill;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;

    assign o_busy      = (r_fill == FCNT_W'(FIFO_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_start && !o_busy;
    assign pop         = i_pop && o_cmd_valid;

    always_comb begin
        cmd_in.opcode = i_item.opcode;
        cmd_in.key    = i_item.item_key;
        cmd_in.value  = VALUE_WIDTH'(i_item.item_value);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: design/swmq_back.sv
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: back end
// Runs queued commands against the entry ring and emits one result each.
// ----------------------------------------------------------------------------
`include "sliding_window_monotonic_queue_defines.svh"

module swmq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [swmq_pkg::MODE_W-1:0]   i_compare_mode,
    input  logic                          i_cmd_valid,
    input  swmq_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_done,
    output swmq_pkg::t_result             o_result
);
    import swmq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TAIL_RD  = 3'd1;
    localparam logic [2:0] S_TAIL_CMP = 3'd2;
    localparam logic [2:0] S_APPEND   = 3'd3;
    localparam logic [2:0] S_KEY_RD   = 3'd4;
    localparam logic [2:0] S_KEY_CMP  = 3'd5;
    localparam logic [2:0] S_HEAD_RD  = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    t_entry             r_mem [DEPTH];
    t_entry             r_rd_data;
    t_cmd               r_cmd;
    logic [2:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    function automatic logic [IDX_W-1:0] ring(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_ovf    = r_ovf;
        o_pop    = 1'b0;
        o_done   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        wr_en    = 1'b0;
        wr_addr  = r_head;
        wr_data.key   = r_cmd.key;
        wr_data.value = r_cmd.value;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_ovf = 1'b0;
                    if (i_cmd.opcode == OP_ADD) begin
                        n_state = (r_count == '0) ? S_APPEND : S_TAIL_RD;
                    end else begin
                        n_state = (r_count == '0) ? S_HEAD_RD : S_KEY_RD;
                    end
                end
            end
            S_TAIL_RD: begin
                rd_en   = 1'b1;
                rd_addr = ring(r_head, r_count - 1'b1);
                n_state = S_TAIL_CMP;
            end
            S_TAIL_CMP: begin
                if (dominated(i_compare_mode, r_rd_data.value, r_cmd.value)) begin
                    n_count = r_count - 1'b1;
                    n_state = (r_count == CNT_W'(1)) ? S_APPEND : S_TAIL_RD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                wr_en = 1'b1;
                if (r_count == CNT_W'(DEPTH)) begin
                    wr_addr = r_head;
                    n_head  = ring(r_head, CNT_W'(1));
                    n_ovf   = 1'b1;
                end else begin
                    wr_addr = ring(r_head, r_count);
                    n_count = r_count + 1'b1;
                end
                n_state = S_HEAD_RD;
            end
            S_KEY_RD: begin
                rd_en   = 1'b1;
                n_state = S_KEY_CMP;
            end
            S_KEY_CMP: begin
                if ($signed(r_rd_data.key) <= $signed(r_cmd.key)) begin
                    n_head  = ring(r_head, CNT_W'(1));
                    n_count = r_count - 1'b1;
                end
                n_state = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                rd_en   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.queue_empty = (r_count == '0);
        o_result.overflow    = r_ovf;
        o_result.best_value  = (r_count == '0) ? '0 : DATA_W'($signed(r_rd_data.value));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    `SWMQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `SWMQ_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, o_done && o_result.overflow, r_count == CNT_W'(DEPTH))
    `SWMQ_ASSERT_NEXT(a_append_nonempty, i_clk, i_rst_n, r_state == S_APPEND, r_count != '0)

endmodule

FILE: design/sliding_window_monotonic_queue.sv
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: top level
// Bounded monotonic deque of (key, value) words for window maximum/minimum.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  item      in         start, busy               i_item  (t_item)
//  result    out        o_done strobe, no stall   o_result (t_result)
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (compare mode)
//
// Add: read and compare each tail entry, append, read head; remove: read and test
// the head key (skipped when empty), read head. Reads share one registered port.
// Reset is synchronous and clears pointers, count and mode; no clearing pass.
// busy rises while the two-word command queue is full; results cannot stall.
module sliding_window_monotonic_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  swmq_pkg::t_item             i_item,
    output logic                        o_done,
    output swmq_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [swmq_pkg::MODE_W-1:0] i_cfg_data
);
    import swmq_pkg::*;

    logic [MODE_W-1:0] r_compare_mode;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_mode <= CMP_LE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compare_mode <= i_cfg_data;
        end
    end

    swmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .i_pop       (pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    swmq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_compare_mode (r_compare_mode),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_result       (o_result)
    );

endmodule

FILE: tb/sliding_window_monotonic_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window monotonic queue: testbench
// Drives add and remove words through the start/busy port and runs a
// window-extremum predictor alongside the block. Every result word is
// compared field by field. The compare mode is switched between phases.
// Stimulus: a short directed table, then sliding-window sequences with
// random content and some noise, under varying sender idle rates.
// ----------------------------------------------------------------------------
module sliding_window_monotonic_queue_tb;
    import swmq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int DIR_N          = 20;
    localparam int PHASE_N        = 6;
    localparam int PHASE_ITEMS    = 150;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    localparam logic [MODE_W-1:0] MODE_PLAN [PHASE_N] =
        '{CMP_GT, CMP_LT, CMP_GE, CMP_LE, CMP_GT, CMP_GE};

    typedef enum int {STYLE_RANDOM, STYLE_NARROW, STYLE_RAMP, STYLE_EXTREME} t_value_style;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_done;
    t_result             o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MODE_W-1:0]   i_cfg_data;

    logic signed [KEY_W-1:0]       ring_key [DEPTH];
    logic signed [VALUE_WIDTH-1:0] ring_val [DEPTH];
    int                            ring_head;
    int                            ring_count;
    logic [MODE_W-1:0]             cmp_mode;

    t_result pending_heads [$];
    int      fail_count;
    int      stall_cycles;
    int      sender_idle_pct;

    t_value_style            win_style;
    int                      win_w;
    int                      seg_left;
    logic [31:0]             win_pos;
    logic signed [31:0]      key_base;
    logic signed [31:0]      ramp_val;
    bit                      remove_next;

    sliding_window_monotonic_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit tail_dominated(input logic signed [VALUE_WIDTH-1:0] back,
                                          input logic signed [VALUE_WIDTH-1:0] nv);
        bit hit;
        case (cmp_mode)
            CMP_LE: hit = (back <= nv);
            CMP_LT: hit = (back <  nv);
            CMP_GE: hit = (back >= nv);
            default: hit = (back > nv);
        endcase
        return hit;
    endfunction

    function automatic t_result window_step(input t_item it);
        t_result                       r;
        logic signed [VALUE_WIDTH-1:0] nv;
        int                            tail;
        r.overflow = 1'b0;
        if (it.opcode == OP_ADD) begin
            nv = $signed(it.item_value);
            while (ring_count > 0 &&
                   tail_dominated(ring_val[(ring_head + ring_count - 1) % DEPTH], nv))
                ring_count--;
            if (ring_count >= DEPTH) begin
                ring_head  = (ring_head + 1) % DEPTH;
                ring_count = DEPTH - 1;
                r.overflow = 1'b1;
            end
            tail = (ring_head + ring_count) % DEPTH;
            ring_key[tail] = $signed(it.item_key);
            ring_val[tail] = nv;
            ring_count++;
        end else if (ring_count > 0 && ring_key[ring_head] <= $signed(it.item_key)) begin
            ring_head  = (ring_head + 1) % DEPTH;
            ring_count--;
        end
        if (ring_count > 0) begin
            r.best_value  = ring_val[ring_head][DATA_W-1:0];
            r.queue_empty = 1'b0;
        end else begin
            r.best_value  = '0;
            r.queue_empty = 1'b1;
        end
        return r;
    endfunction

    function automatic t_item next_window_item();
        t_item it;
        it.item_value = $urandom();
        if (win_style != STYLE_RAMP && $urandom_range(99) < 8) begin
            it.opcode   = 1'($urandom_range(1));
            it.item_key = $urandom();
            return it;
        end
        if (seg_left == 0) begin
            win_style = t_value_style'($urandom_range(3));
            win_w     = $urandom_range(1, 96);
            seg_left  = $urandom_range(20, 90);
        end
        if (remove_next) begin
            it.opcode   = OP_REMOVE;
            it.item_key = key_base + win_pos - win_w;
            remove_next = 1'b0;
            seg_left--;
            win_pos++;
            return it;
        end
        it.opcode   = OP_ADD;
        it.item_key = key_base + win_pos;
        case (win_style)
            STYLE_NARROW: it.item_value = int'($urandom_range(0, 8)) - 4;
            STYLE_RAMP: begin
                if (cmp_mode < CMP_GE)
                    ramp_val = ramp_val - int'($urandom_range(1, 1000));
                else
                    ramp_val = ramp_val + int'($urandom_range(1, 1000));
                it.item_value = ramp_val;
            end
            STYLE_EXTREME: begin
                case ($urandom_range(3))
                    0: it.item_value = VAL_MAX;
                    1: it.item_value = VAL_MIN;
                    2: it.item_value = '0;
                    default: it.item_value = '1;
                endcase
            end
            default: ;
        endcase
        remove_next = 1'b1;
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        res = window_step(it);
        pending_heads.push_back(typed ? typed_res : res);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_heads.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_compare_mode(input logic [MODE_W-1:0] mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cmp_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_heads.size() == 0) begin
                $error("result word with nothing expected: best_value %0d",
                       $signed(o_result.best_value));
                fail_count++;
            end else begin
                want = pending_heads[0];
                pending_heads.delete(0);
                if (o_result.best_value !== want.best_value) begin
                    $error("best_value: expected %0d, got %0d",
                           $signed(want.best_value), $signed(o_result.best_value));
                    fail_count++;
                end
                if (o_result.queue_empty !== want.queue_empty) begin
                    $error("queue_empty: expected %0b, got %0b",
                           want.queue_empty, o_result.queue_empty);
                    fail_count++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, o_result.overflow);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAIL sliding_window_monotonic_queue");
        $finish;
    end

    initial begin
        t_dir_row rows [DIR_N];
        int       sp;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        sender_idle_pct = 19;
        ring_head       = 0;
        ring_count      = 0;
        cmp_mode        = CMP_LE;
        win_style       = STYLE_RANDOM;
        win_w           = 1;
        seg_left        = 0;
        win_pos         = '0;
        key_base        = '0;
        ramp_val        = '0;
        remove_next     = 1'b0;

        rows[0]  = '{'{OP_REMOVE, 32'h0, 32'h0},              1'b1, '{32'h0, 1'b1, 1'b0}};
        rows[1]  = '{'{OP_ADD, VAL_MAX, VAL_MAX},             1'b1, '{VAL_MAX, 1'b0, 1'b0}};
        rows[2]  = '{'{OP_REMOVE, VAL_MAX - 1, 32'hFFFF_FFFF}, 1'b1, '{VAL_MAX, 1'b0, 1'b0}};
        rows[3]  = '{'{OP_ADD, VAL_MIN, VAL_MIN},             1'b1, '{VAL_MAX, 1'b0, 1'b0}};
        rows[4]  = '{'{OP_REMOVE, VAL_MAX, 32'h0},            1'b1, '{VAL_MIN, 1'b0, 1'b0}};
        rows[5]  = '{'{OP_REMOVE, VAL_MIN, 32'h0},            1'b1, '{32'h0, 1'b1, 1'b0}};
        rows[6]  = '{'{OP_REMOVE, VAL_MAX, 32'h0},            1'b1, '{32'h0, 1'b1, 1'b0}};
        rows[7]  = '{'{OP_ADD, 32'd1, 32'd0},                 1'b0, '0};
        rows[8]  = '{'{OP_ADD, 32'd2, 32'd0},                 1'b0, '0};
        rows[9]  = '{'{OP_ADD, 32'd3, -32'sd5},               1'b0, '0};
        rows[10] = '{'{OP_ADD, 32'd4, 32'd3},                 1'b0, '0};
        rows[11] = '{'{OP_ADD, 32'd5, 32'd2},                 1'b0, '0};
        rows[12] = '{'{OP_ADD, 32'd6, 32'd2},                 1'b0, '0};
        rows[13] = '{'{OP_REMOVE, 32'd3, 32'h0},              1'b0, '0};
        rows[14] = '{'{OP_REMOVE, 32'd4, 32'h0},              1'b0, '0};
        rows[15] = '{'{OP_REMOVE, VAL_MAX, 32'h0},            1'b0, '0};
        rows[16] = '{'{OP_REMOVE, VAL_MAX, 32'h0},            1'b0, '0};
        rows[17] = '{'{OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0};
        rows[18] = '{'{OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0};
        rows[19] = '{'{OP_REMOVE, 32'h5555_5555, 32'h0},      1'b0, '0};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_item(rows[i].it, rows[i].typed, rows[i].res);
        finish_phase();

        for (sp = 0; sp < PHASE_N; sp++) begin
            set_compare_mode(MODE_PLAN[sp]);
            sender_idle_pct = (sp < 2) ? 19 : (sp < 4) ? 81 : 0;
            key_base    = $urandom();
            win_pos     = '0;
            remove_next = 1'b0;
            seg_left    = 0;
            // fill the store with a monotone run to force the oldest word out
            if (sp == 0 || sp == 3) begin
                win_style = STYLE_RAMP;
                win_w     = 72;
                seg_left  = 75;
                ramp_val  = '0;
            end
            repeat (PHASE_ITEMS) send_item(next_window_item(), 1'b0, '0);
            finish_phase();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS sliding_window_monotonic_queue");
        else
            $display("FAIL sliding_window_monotonic_queue");
        $finish;
    end

endmodule
